[sv/heater_hysteresis_min_on_off_macros.svh]
// assertion helpers for the heater controller
`ifndef HEATER_HYSTERESIS_MIN_ON_OFF_MACROS_SVH
`define HEATER_HYSTERESIS_MIN_ON_OFF_MACROS_SVH

// same-cycle implication, checked out of reset
`define HHM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heater controller check failed");

// next-cycle implication, checked out of reset
`define HHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heater controller check failed");

`endif

[sv/hhm_pkg.sv]
`timescale 1ns / 1ps

package hhm_pkg;

    localparam int NUM_LEVELS_DEF = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF     = 3'd5;

    // register reset values
    localparam logic [3:0] RST_POWER_LEVEL = 4'd0;
    localparam logic [7:0] RST_UP_BAND     = 8'd3;
    localparam logic [7:0] RST_DOWN_BAND   = 8'd1;
    localparam logic [7:0] RST_OVER_BAND   = 8'd5;
    localparam logic [7:0] RST_UNDER_BAND  = 8'd0;
    localparam logic [7:0] RST_MIN_OFF     = 8'd30;

    localparam logic [8:0] PREHEAT_NEAR = 9'd4;
    localparam logic [3:0] PAUSE_LOAD   = 4'd10;
    localparam logic [2:0] START_DRIVE  = 3'd5;
    localparam logic [2:0] DRIVE_ON     = 3'd1;
    localparam logic [2:0] DRIVE_OFF    = 3'd0;
    localparam logic [7:0] SAT_MAX      = 8'd255;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_PREHEAT  = 2'd1,
        PH_REGULATE = 2'd2
    } phase_t;

    // settings seen by the control step
    typedef struct packed {
        logic [7:0] goal;
        logic [7:0] min_on;
        logic [7:0] up_band;
        logic [7:0] down_band;
        logic [7:0] over_band;
        logic [7:0] under_band;
        logic [7:0] min_off;
    } ctrl_cfg_t;

    function automatic logic [7:0] goal_lookup(input logic [3:0] idx);
        logic [7:0] g;
        case (idx)
            4'd0:    g = 8'd9;
            4'd1:    g = 8'd12;
            4'd2:    g = 8'd16;
            default: g = 8'd19;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] min_on_lookup(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'd20;
            4'd1:    m = 8'd30;
            4'd2:    m = 8'd40;
            default: m = 8'd50;
        endcase
        return m;
    endfunction

endpackage

[sv/hhm_cfg_regs.sv]
`timescale 1ns / 1ps

module hhm_cfg_regs
    import hhm_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output ctrl_cfg_t             cfg
);

    logic [3:0] power_level_reg;
    logic [7:0] up_band_reg;
    logic [7:0] down_band_reg;
    logic [7:0] over_band_reg;
    logic [7:0] under_band_reg;
    logic [7:0] min_off_reg;
    logic [3:0] level_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_level_reg <= RST_POWER_LEVEL;
            up_band_reg     <= RST_UP_BAND;
            down_band_reg   <= RST_DOWN_BAND;
            over_band_reg   <= RST_OVER_BAND;
            under_band_reg  <= RST_UNDER_BAND;
            min_off_reg     <= RST_MIN_OFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POWER_LEVEL: power_level_reg <= cfg_wdata[3:0];
                CFG_UP_BAND:     up_band_reg     <= cfg_wdata;
                CFG_DOWN_BAND:   down_band_reg   <= cfg_wdata;
                CFG_OVER_BAND:   over_band_reg   <= cfg_wdata;
                CFG_UNDER_BAND:  under_band_reg  <= cfg_wdata;
                CFG_MIN_OFF:     min_off_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // out-of-range levels use the top table entry
    assign level_idx = ({1'b0, power_level_reg} >= 5'(NUM_LEVELS)) ?
                       4'(NUM_LEVELS - 1) : power_level_reg;

    assign cfg.goal       = goal_lookup(level_idx);
    assign cfg.min_on     = min_on_lookup(level_idx);
    assign cfg.up_band    = up_band_reg;
    assign cfg.down_band  = down_band_reg;
    assign cfg.over_band  = over_band_reg;
    assign cfg.under_band = under_band_reg;
    assign cfg.min_off    = min_off_reg;

endmodule

[sv/hhm_step.sv]
`timescale 1ns / 1ps

module hhm_step
    import hhm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] now_temp,
    input  logic       second_tick,
    input  ctrl_cfg_t  cfg,
    output logic [2:0] heat_level,
    output logic       heating_request,
    output logic [1:0] phase
);

    phase_t     phase_reg, phase_next;
    logic       heater_on_reg, heater_on_next;
    logic [7:0] on_sec_reg, on_sec_next;
    logic [7:0] off_sec_reg, off_sec_next;
    logic [3:0] pause_reg, pause_next;

    logic [7:0] on_mid, off_mid;
    logic [3:0] pause_mid;
    logic [2:0] level;
    logic [8:0] now9, goal9;
    logic       near_goal, above_over, below_under, below_down, above_up;
    logic       regulate_on;

    assign now9  = {1'b0, now_temp};
    assign goal9 = {1'b0, cfg.goal};

    // 9-bit compares, no wrap on the band limits
    assign near_goal   = (now9 + PREHEAT_NEAR) > goal9;
    assign above_over  = now9 > (goal9 + {1'b0, cfg.over_band});
    assign below_under = (now9 + {1'b0, cfg.under_band}) <= goal9;
    assign below_down  = now9 <= (goal9 + {1'b0, cfg.down_band});
    assign above_up    = now9 > (goal9 + {1'b0, cfg.up_band});

    always_comb begin
        if (above_over) begin
            regulate_on = 1'b0;
        end else if (below_under) begin
            regulate_on = 1'b1;
        end else if (!heater_on_reg) begin
            regulate_on = (off_sec_reg > cfg.min_off) && below_down;
        end else begin
            regulate_on = !((on_sec_reg > cfg.min_on) && above_up);
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        heater_on_next = heater_on_reg;
        on_mid         = on_sec_reg;
        off_mid        = off_sec_reg;
        pause_mid      = pause_reg;
        level          = DRIVE_OFF;
        unique case (phase_reg)
            PH_START: begin
                phase_next = PH_PREHEAT;
                on_mid     = '0;
                off_mid    = '0;
                pause_mid  = '0;
                level      = START_DRIVE;
            end
            PH_PREHEAT: begin
                if (near_goal) begin
                    pause_mid      = PAUSE_LOAD;
                    heater_on_next = 1'b0;
                    phase_next     = PH_REGULATE;
                end else begin
                    level = DRIVE_ON;
                end
            end
            PH_REGULATE: begin
                heater_on_next = regulate_on;
                level          = regulate_on ? DRIVE_ON : DRIVE_OFF;
            end
            default: begin
                phase_next = PH_PREHEAT;
            end
        endcase

        pause_next = pause_mid;
        if (pause_mid != '0) begin
            if (second_tick) begin
                pause_next = pause_mid - 4'd1;
            end
            level = DRIVE_OFF;
        end

        if (heater_on_next) begin
            on_sec_next  = (second_tick && on_mid != SAT_MAX) ? on_mid + 8'd1 : on_mid;
            off_sec_next = '0;
        end else begin
            off_sec_next = (second_tick && off_mid != SAT_MAX) ? off_mid + 8'd1 : off_mid;
            on_sec_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            heater_on_reg <= 1'b0;
            on_sec_reg    <= '0;
            off_sec_reg   <= '0;
            pause_reg     <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            heater_on_reg <= heater_on_next;
            on_sec_reg    <= on_sec_next;
            off_sec_reg   <= off_sec_next;
            pause_reg     <= pause_next;
        end
    end

    assign heat_level      = level;
    assign heating_request = heater_on_next;
    assign phase           = phase_next;

endmodule

[sv/heater_hysteresis_min_on_off.sv]
`timescale 1ns / 1ps

// bang-bang heater controller with hysteresis and minimum on/off times. every
// request (temperature reading plus one-second tick flag) gives exactly one
// result: drive level, heater-on flag and control phase. a request sits in an
// input register, the control step runs as plain compare logic, and the result
// is held in an output register until taken; throughput is one request per
// cycle while the result side is not stalled. the request is loaded into the
// input register at the accepting edge and its result into the output register
// when the step advances, which raises m_valid. a stalled result holds the step,
// so at most two requests are in flight. the power level selects a goal
// reading and minimum on-time from a fixed table; the config port takes
// writes at any time but should only be used while idle.

`include "heater_hysteresis_min_on_off_macros.svh"

module heater_hysteresis_min_on_off
    import hhm_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_now_temp,
    input  logic                  s_second_tick,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_heat_level,
    output logic                  m_heating_request,
    output logic [1:0]            m_phase
);

    ctrl_cfg_t  cfg;

    // input register
    logic       in_valid_reg;
    logic [7:0] now_temp_reg;
    logic       tick_reg;

    // output register
    logic       out_valid_reg;
    logic [2:0] heat_level_reg;
    logic       heating_request_reg;
    logic [1:0] phase_reg;

    // step results
    logic [2:0] step_level;
    logic       step_request;
    logic [1:0] step_phase;

    logic       advance;
    logic       s_accept;

    // terms for the checks below
    logic       start_out;
    logic       regulate_live;
    logic       live_on;
    logic       full_stall;
    logic       pipe_drained;

    // the held request moves on when the output slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    hhm_cfg_regs #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hhm_step u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .now_temp        (now_temp_reg),
        .second_tick     (tick_reg),
        .cfg             (cfg),
        .heat_level      (step_level),
        .heating_request (step_request),
        .phase           (step_phase)
    );

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_temp_reg <= s_now_temp;
            tick_reg     <= s_second_tick;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload captured as the step state commits
    always_ff @(posedge aclk) begin
        if (advance) begin
            heat_level_reg      <= step_level;
            heating_request_reg <= step_request;
            phase_reg           <= step_phase;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_heat_level      = heat_level_reg;
    assign m_heating_request = heating_request_reg;
    assign m_phase           = phase_reg;

    assign start_out     = m_valid && m_heat_level == START_DRIVE;
    assign regulate_live = m_valid && m_phase == PH_REGULATE && m_heat_level != DRIVE_OFF;
    assign live_on       = m_heating_request && m_heat_level == DRIVE_ON;
    assign full_stall    = in_valid_reg && out_valid_reg && !m_ready;
    assign pipe_drained  = !in_valid_reg && (!out_valid_reg || m_ready);

    // start drive only ever leaves with the block entering preheat
    `HHM_ASSERT_NOW(a_start_drive_phase, aclk, aresetn, start_out, m_phase == PH_PREHEAT)

    // in regulate a live drive always matches the heater-on decision
    `HHM_ASSERT_NOW(a_regulate_drive, aclk, aresetn, regulate_live, live_on)

    // a full pipe with a stalled result must not take another request
    `HHM_ASSERT_NOW(a_full_stall, aclk, aresetn, full_stall, !s_ready)

    // a result handed on always comes from a held request
    `HHM_ASSERT_NEXT(a_result_source, aclk, aresetn, pipe_drained, !m_valid)

endmodule

[bench/hhm_drive_checker.sv]
`timescale 1ns / 1ps

module hhm_drive_checker
    import hhm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_now_temp,
    input  logic                  s_second_tick,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [2:0]            m_heat_level,
    input  logic                  m_heating_request,
    input  logic [1:0]            m_phase,
    output int                    mismatch_count,
    output int                    pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0] level;
        logic       request;
        logic [1:0] ph;
    } drive_t;

    drive_t expected_drive[$];

    // shadow settings
    logic [3:0] power_sel;
    logic [7:0] up_b, down_b, over_b, under_b, min_off;

    // controller state
    phase_t     ctrl_ph;
    logic       heater_on;
    logic [7:0] on_secs, off_secs;
    logic [3:0] pause_left;

    int fault_tally;

    function automatic int clamp_level(input logic [3:0] lvl);
        return (int'(lvl) >= NUM_LEVELS_DEF) ? NUM_LEVELS_DEF - 1 : int'(lvl);
    endfunction

    function automatic int goal_for(input int sel);
        case (sel)
            0:       return 9;
            1:       return 12;
            2:       return 16;
            default: return 19;
        endcase
    endfunction

    function automatic int min_on_for(input int sel);
        case (sel)
            0:       return 20;
            1:       return 30;
            2:       return 40;
            default: return 50;
        endcase
    endfunction

    function automatic drive_t advance_controller(input logic [7:0] temp, input logic tick);
        int     sel, goal, min_on, now_i, diff;
        drive_t d;
        sel    = clamp_level(power_sel);
        goal   = goal_for(sel);
        min_on = min_on_for(sel);
        now_i  = int'(temp);
        diff   = (goal > now_i) ? goal - now_i : 0;
        d.level = DRIVE_OFF;
        case (ctrl_ph)
            PH_START: begin
                ctrl_ph    = PH_PREHEAT;
                on_secs    = '0;
                off_secs   = '0;
                pause_left = '0;
                d.level    = START_DRIVE;
            end
            PH_PREHEAT: begin
                if (diff < int'(PREHEAT_NEAR)) begin
                    pause_left = PAUSE_LOAD;
                    heater_on  = 1'b0;
                    ctrl_ph    = PH_REGULATE;
                end else begin
                    d.level = DRIVE_ON;
                end
            end
            PH_REGULATE: begin
                // limits are plain integers, so a negative lower limit never matches
                if (now_i > goal + int'(over_b)) begin
                    heater_on = 1'b0;
                end else if (now_i <= goal - int'(under_b)) begin
                    heater_on = 1'b1;
                end else if (!heater_on) begin
                    if (int'(off_secs) > int'(min_off) && now_i <= goal + int'(down_b))
                        heater_on = 1'b1;
                end else begin
                    if (int'(on_secs) > min_on && now_i > goal + int'(up_b))
                        heater_on = 1'b0;
                end
                d.level = heater_on ? DRIVE_ON : DRIVE_OFF;
            end
            default: begin
                ctrl_ph = PH_PREHEAT;
                d.level = DRIVE_OFF;
            end
        endcase
        if (pause_left != '0) begin
            if (tick)
                pause_left = pause_left - 4'd1;
            d.level = DRIVE_OFF;
        end
        if (heater_on) begin
            if (tick && on_secs != SAT_MAX)
                on_secs = on_secs + 8'd1;
            off_secs = '0;
        end else begin
            if (tick && off_secs != SAT_MAX)
                off_secs = off_secs + 8'd1;
            on_secs = '0;
        end
        d.request = heater_on;
        d.ph      = ctrl_ph;
        return d;
    endfunction

    always @(posedge aclk) begin
        drive_t got, want;
        int     delta;
        if (!aresetn) begin
            power_sel   = RST_POWER_LEVEL;
            up_b        = RST_UP_BAND;
            down_b      = RST_DOWN_BAND;
            over_b      = RST_OVER_BAND;
            under_b     = RST_UNDER_BAND;
            min_off     = RST_MIN_OFF;
            ctrl_ph     = PH_START;
            heater_on   = 1'b0;
            on_secs     = '0;
            off_secs    = '0;
            pause_left  = '0;
            fault_tally = 0;
            expected_drive.delete();
            mismatch_count <= 0;
            pending        <= 0;
        end else begin
            delta = 0;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POWER_LEVEL: power_sel = cfg_wdata[3:0];
                    CFG_UP_BAND:     up_b      = cfg_wdata;
                    CFG_DOWN_BAND:   down_b    = cfg_wdata;
                    CFG_OVER_BAND:   over_b    = cfg_wdata;
                    CFG_UNDER_BAND:  under_b   = cfg_wdata;
                    CFG_MIN_OFF:     min_off   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_drive.push_back(advance_controller(s_now_temp, s_second_tick));
                delta++;
            end
            if (m_valid && m_ready) begin
                got = {m_heat_level, m_heating_request, m_phase};
                if (expected_drive.size() == 0) begin
                    fault_tally++;
                    if (fault_tally <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: level %0d request %0d phase %0d",
                                 $realtime, got.level, got.request, got.ph);
                end else begin
                    want = expected_drive.pop_front();
                    delta--;
                    if (got.level !== want.level || got.request !== want.request ||
                        got.ph !== want.ph) begin
                        fault_tally++;
                        if (fault_tally <= REPORT_LIMIT)
                            $display("%0t: drive mismatch: level exp %0d got %0d, request exp %0d got %0d, phase exp %0d got %0d",
                                     $realtime, want.level, got.level, want.request,
                                     got.request, want.ph, got.ph);
                    end
                end
            end
            mismatch_count <= fault_tally;
            pending        <= pending + delta;
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import hhm_pkg::*;

    // config indexes that have no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // streak length: enough ticks to push a seconds counter into saturation
    localparam int STREAK_LEN = 262;
    localparam int WALK_LEN   = 24;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_POWER_LEVEL;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_now_temp = '0;
    logic                  s_second_tick = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_heat_level;
    logic                  m_heating_request;
    logic [1:0]            m_phase;

    int mismatch_count;
    int pending;

    // idling odds, in percent
    int send_idle_pct = 0;
    int stall_pct = 0;

    // temperature random walk state
    int walk_temp = 12;
    int walk_dir = 1;

    heater_hysteresis_min_on_off uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_temp        (s_now_temp),
        .s_second_tick     (s_second_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_heat_level      (m_heat_level),
        .m_heating_request (m_heating_request),
        .m_phase           (m_phase)
    );

    hhm_drive_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_temp        (s_now_temp),
        .s_second_tick     (s_second_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_heat_level      (m_heat_level),
        .m_heating_request (m_heating_request),
        .m_phase           (m_phase),
        .mismatch_count    (mismatch_count),
        .pending           (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one request: optional idle gap, then hold valid until it is taken
    task automatic push_reading(input logic [7:0] temp, input logic tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_now_temp    <= temp;
        s_second_tick <= tick;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // write every register back to back; only called while the block is idle
    task automatic load_settings(input logic [7:0] pwr, input logic [7:0] up,
                                 input logic [7:0] dn, input logic [7:0] ov,
                                 input logic [7:0] un, input logic [7:0] moff,
                                 input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POWER_LEVEL;
        cfg_wdata <= pwr;
        @(posedge aclk);
        cfg_index <= CFG_UP_BAND;
        cfg_wdata <= up;
        @(posedge aclk);
        cfg_index <= CFG_DOWN_BAND;
        cfg_wdata <= dn;
        @(posedge aclk);
        cfg_index <= CFG_OVER_BAND;
        cfg_wdata <= ov;
        @(posedge aclk);
        cfg_index <= CFG_UNDER_BAND;
        cfg_wdata <= un;
        @(posedge aclk);
        cfg_index <= CFG_MIN_OFF;
        cfg_wdata <= moff;
        @(posedge aclk);
        if (poke_spare) begin
            // writes to unused indexes must leave every register alone
            cfg_index <= CFG_SPARE_LO;
            cfg_wdata <= 8'($urandom_range(255));
            @(posedge aclk);
            cfg_index <= CFG_SPARE_HI;
            cfg_wdata <= 8'($urandom_range(255));
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // slow drift around the goal readings with occasional wild readings thrown in
    function automatic logic [7:0] next_reading();
        if ($urandom_range(99) < 8)
            return 8'($urandom_range(255));
        if ($urandom_range(19) == 0)
            walk_dir = -walk_dir;
        if (walk_temp >= 40)
            walk_dir = -1;
        else if (walk_temp <= 0)
            walk_dir = 1;
        walk_temp = walk_temp + walk_dir * int'($urandom_range(2));
        if (walk_temp < 0)
            walk_temp = 0;
        return 8'(walk_temp);
    endfunction

    task automatic run_walk(input int count);
        for (int k = 0; k < count; k++)
            push_reading(next_reading(), $urandom_range(3) != 0);
    endtask

    // long run of ticking requests in one temperature window
    task automatic run_streak(input int lo, input int hi, input int count);
        for (int k = 0; k < count; k++)
            push_reading(8'($urandom_range(hi, lo)), 1'b1);
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings: goal 9, bands 3/1/5/0, min off 30
        push_reading(8'd200, 1'b1);    // start request: drive 5, counters cleared
        push_reading(8'd0,   1'b0);    // preheat, far below goal: drive 1, heater flag still low
        push_reading(8'd5,   1'b1);    // exactly four below goal stays in preheat
        push_reading(8'd6,   1'b1);    // near goal: pause loaded and counting on this very tick
        push_reading(8'd255, 1'b1);    // over limit during the pause: off, drive forced to 0
        push_reading(8'd0,   1'b0);    // under limit during the pause: heater on, drive still 0
        push_reading(8'd9,   1'b1);
        push_reading(8'd12,  1'b1);
        push_reading(8'd10,  1'b1);
        push_reading(8'd14,  1'b1);
        push_reading(8'd15,  1'b1);
        push_reading(8'd8,   1'b1);
        push_reading(8'd11,  1'b1);
        push_reading(8'd13,  1'b1);    // pause runs out around here
        push_reading(8'd170, 1'b0);
        push_reading(8'd85,  1'b1);
        push_reading(8'd9,   1'b0);    // reading equal to goal
        push_reading(8'd10,  1'b1);
        push_reading(8'd13,  1'b1);    // above up band but min on-time not yet met
        push_reading(8'd14,  1'b1);    // inside the over band
        push_reading(8'd0,   1'b1);
        push_reading(8'd255, 1'b0);
        drain_results();

        // zero min off-time; power written with junk in the upper nibble
        load_settings(8'hF0, 8'd3, 8'd1, 8'd5, 8'd0, 8'd0, 1'b0);
        set_idling(0, 0);
        run_walk(WALK_LEN);
        drain_results();

        // every band and the off-time at the top: lower limit goes negative
        load_settings(8'd9, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        set_idling(65, 0);
        run_walk(WALK_LEN);
        drain_results();

        // power out of range clamps to the last entry; zero bands, hot streak
        // saturates the off-seconds counter
        load_settings(8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 1'b1);
        set_idling(0, 65);
        run_streak(20, 255, STREAK_LEN);
        run_walk(WALK_LEN / 2);
        drain_results();               // sender holds off until everything is back
        run_walk(WALK_LEN / 2);
        drain_results();

        // moderate bands; cold streak holds the heater on until on-seconds saturate
        load_settings(8'd2, 8'd8, 8'd2, 8'd30, 8'd6, 8'd20, 1'b0);
        set_idling(27, 27);
        run_streak(0, 10, STREAK_LEN);
        run_walk(WALK_LEN);
        drain_results();

        // random settings, including stray upper bits on the power level
        load_settings(8'($urandom_range(255)), 8'($urandom_range(12)),
                      8'($urandom_range(12)), 8'($urandom_range(40)),
                      8'($urandom_range(20)), 8'($urandom_range(40)), 1'b1);
        set_idling(0, 0);
        run_walk(WALK_LEN);
        drain_results();

        load_settings(8'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'b1);
        set_idling(65, 0);
        run_walk(WALK_LEN);
        drain_results();

        load_settings(8'($urandom_range(15)), 8'($urandom_range(6)),
                      8'($urandom_range(6)), 8'($urandom_range(15)),
                      8'($urandom_range(15)), 8'($urandom_range(10)), 1'b0);
        set_idling(27, 27);
        run_walk(WALK_LEN);
        drain_results();

        // the wait below leaves plenty of room for stray results
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
